@@ src/qsv_pkg.sv @@
package qsv_pkg;

  localparam int MAX_QUBITS = 10;
  localparam int AMP_BITS   = 18;
  localparam int FRAC_BITS  = AMP_BITS - 2;
  localparam int STORE_AW   = MAX_QUBITS;
  localparam int STORE_DEPTH = 1 << MAX_QUBITS;
  localparam int PAIR_W     = MAX_QUBITS - 1;
  localparam int ENTRY_W    = 2 * AMP_BITS;
  localparam int QC_W       = 4;
  localparam int QIDX_W     = 4;
  localparam int REQ_W      = 3;
  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;

  localparam int SUM_W      = AMP_BITS + 1;
  localparam int COEF_W     = 17;
  localparam int PROD_W     = SUM_W + COEF_W;
  localparam int HAD_SHIFT  = 16;
  localparam int RND_W      = PROD_W - HAD_SHIFT;

  localparam logic signed [COEF_W-1:0] HAD_COEF = COEF_W'(46341);

  localparam logic signed [AMP_BITS-1:0] AMP_MAX = AMP_BITS'((1 << (AMP_BITS - 1)) - 1);
  localparam logic signed [AMP_BITS-1:0] AMP_MIN = AMP_BITS'(1 << (AMP_BITS - 1));
  localparam logic signed [AMP_BITS-1:0] AMP_ONE = AMP_BITS'(1 << FRAC_BITS);

  localparam logic [RND_W-1:0] RND_POS_LIM = RND_W'((1 << (AMP_BITS - 1)) - 1);
  localparam logic [RND_W-1:0] RND_NEG_LIM = RND_W'(1 << (AMP_BITS - 1));
  localparam logic [PROD_W-1:0] RND_HALF   = PROD_W'(1 << (HAD_SHIFT - 1));

  localparam logic [REQ_W-1:0] REQ_INIT = 3'd0;
  localparam logic [REQ_W-1:0] REQ_HAD  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_X    = 3'd2;
  localparam logic [REQ_W-1:0] REQ_Y    = 3'd3;
  localparam logic [REQ_W-1:0] REQ_Z    = 3'd4;
  localparam logic [REQ_W-1:0] REQ_CNOT = 3'd5;
  localparam logic [REQ_W-1:0] REQ_READ = 3'd6;

  localparam logic REG_QUBIT_COUNT = 1'b0;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_RD_A,
    S_RD_B,
    S_LATCH,
    S_MUL,
    S_WR_A,
    S_WR_B,
    S_AMP,
    S_AMP_DATA,
    S_DONE
  } state_t;

  function automatic logic signed [AMP_BITS-1:0] neg_sat(input logic signed [AMP_BITS-1:0] x);
    if (x == AMP_MIN) begin
      return AMP_MAX;
    end
    return -x;
  endfunction

  // Round half away from zero after the 2^-16 scale, then clamp.
  function automatic logic signed [AMP_BITS-1:0] had_round(input logic signed [PROD_W-1:0] p);
    logic             neg;
    logic [PROD_W-1:0] mag;
    logic [PROD_W-1:0] sum;
    logic [RND_W-1:0]  r;
    neg = p[PROD_W-1];
    mag = neg ? PROD_W'(-p) : PROD_W'(p);
    sum = mag + RND_HALF;
    r   = sum[PROD_W-1:HAD_SHIFT];
    if (neg) begin
      if (r > RND_NEG_LIM) begin
        return AMP_MIN;
      end
      return -$signed(r[AMP_BITS-1:0]);
    end
    if (r > RND_POS_LIM) begin
      return AMP_MAX;
    end
    return $signed(r[AMP_BITS-1:0]);
  endfunction

endpackage

@@ src/qsv_ram.sv @@
module qsv_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/qubit_state_vector_gate_engine.sv @@
// State vector engine for up to ten qubits: 1024 complex amplitudes in Q2.16,
// held in a single-port-read, single-port-write RAM.
// Request channel (req_valid/req_stall): req_type, target_qubit, control_qubit,
// amp_index. One beat in gives exactly one response beat (rsp_valid/rsp_stall)
// carrying amp_real, amp_imag and status. req_stall stays high from the beat
// taken until the response has been loaded into the output register, so one
// request is in flight at a time; the response register lets the engine take
// the next request while the previous response still waits for the receiver.
// Per amplitude pair the engine reads both entries, latches them and writes
// both back; Hadamard adds a multiply step between latch and write, and CNOT
// skips the pairs whose control bit is clear. The pair loop is bound by the
// one RAM read and one write port and, for Hadamard, by the one multiplier
// shared over the four products of a pair. Init and the pass after reset
// write all 1024 entries, one per cycle; init then answers, reset does not.
// A read fetches the entry and answers; bad requests answer with status set.
// Reset (rst, synchronous) sets qubit_count to 1 and starts the clearing pass;
// req_stall is high for the whole pass. qubit_count sits on the APB port at
// address 0; the user must write it only while no request is in flight, and the block itself does not enforce it.
module qubit_state_vector_gate_engine (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  req_valid,
  output logic                                  req_stall,
  input  logic [qsv_pkg::REQ_W-1:0]             req_type,
  input  logic [qsv_pkg::QIDX_W-1:0]            target_qubit,
  input  logic [qsv_pkg::QIDX_W-1:0]            control_qubit,
  input  logic [qsv_pkg::STORE_AW-1:0]          amp_index,
  output logic                                  rsp_valid,
  input  logic                                  rsp_stall,
  output logic signed [qsv_pkg::AMP_BITS-1:0]   amp_real,
  output logic signed [qsv_pkg::AMP_BITS-1:0]   amp_imag,
  output logic                                  status,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [qsv_pkg::PADDR_W-1:0]           paddr,
  input  logic [qsv_pkg::PDATA_W-1:0]           pwdata,
  output logic [qsv_pkg::PDATA_W-1:0]           prdata,
  output logic                                  pready
);

  qsv_pkg::state_t state, state_next;

  logic [qsv_pkg::QC_W-1:0]      qubit_count;
  logic [qsv_pkg::QC_W-1:0]      n_eff;
  logic [qsv_pkg::STORE_AW:0]    dim;
  logic [qsv_pkg::PAIR_W-1:0]    last_pair;

  logic [qsv_pkg::REQ_W-1:0]     req_r;
  logic [qsv_pkg::QIDX_W-1:0]    tq_r;
  logic [qsv_pkg::QIDX_W-1:0]    cq_r;
  logic [qsv_pkg::STORE_AW-1:0]  idx_r;

  logic [qsv_pkg::STORE_AW-1:0]  clr_addr;
  logic                          clr_reply;
  logic [qsv_pkg::PAIR_W-1:0]    cnt;
  logic [2:0]                    k;

  logic signed [qsv_pkg::AMP_BITS-1:0] ar, ai, br, bi;
  logic signed [qsv_pkg::AMP_BITS-1:0] hres [4];
  logic signed [qsv_pkg::PROD_W-1:0]   prod;
  logic signed [qsv_pkg::SUM_W-1:0]    mul_op;

  logic signed [qsv_pkg::AMP_BITS-1:0] res_real, res_imag;
  logic                                res_status;

  logic [qsv_pkg::STORE_AW-1:0]  tbit;
  logic [qsv_pkg::PAIR_W-1:0]    low_mask;
  logic [qsv_pkg::STORE_AW-1:0]  addr_i, addr_j;
  logic                          pair_last;
  logic                          cnot_skip;

  logic                          ram_we;
  logic [qsv_pkg::STORE_AW-1:0]  ram_waddr, ram_raddr;
  logic [qsv_pkg::ENTRY_W-1:0]   ram_wdata, ram_rdata;
  logic [qsv_pkg::ENTRY_W-1:0]   new_a, new_b;

  logic req_take, rsp_load;
  logic gate_ok, cnot_ok, read_ok;

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == qsv_pkg::REG_QUBIT_COUNT)
                  ? qsv_pkg::PDATA_W'(qubit_count) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      qubit_count <= qsv_pkg::QC_W'(1);
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == qsv_pkg::REG_QUBIT_COUNT) begin
      qubit_count <= pwdata[qsv_pkg::QC_W-1:0];
    end
  end

  assign n_eff = (qubit_count > qsv_pkg::QC_W'(qsv_pkg::MAX_QUBITS))
                 ? qsv_pkg::QC_W'(qsv_pkg::MAX_QUBITS) : qubit_count;
  assign dim   = (qsv_pkg::STORE_AW + 1)'(1) << n_eff;
  assign last_pair = qsv_pkg::PAIR_W'(dim >> 1) - 1'b1;

  assign gate_ok = target_qubit < n_eff;
  assign cnot_ok = (target_qubit < n_eff) && (control_qubit < n_eff) &&
                   (target_qubit != control_qubit);
  assign read_ok = {1'b0, amp_index} < dim;

  // pair addresses: insert a zero at the target bit of the pair counter
  assign tbit     = qsv_pkg::STORE_AW'(1) << tq_r;
  assign low_mask = tbit[qsv_pkg::PAIR_W-1:0] - 1'b1;
  assign addr_i   = {cnt & ~low_mask, 1'b0} | {1'b0, cnt & low_mask};
  assign addr_j   = addr_i | tbit;
  assign pair_last = cnt == last_pair;
  assign cnot_skip = (req_r == qsv_pkg::REQ_CNOT) && !addr_i[cq_r];

  assign req_stall = state != qsv_pkg::S_IDLE;
  assign req_take  = req_valid && !req_stall;
  assign rsp_load  = (state == qsv_pkg::S_DONE) && (!rsp_valid || !rsp_stall);

  // pair update
  always_comb begin
    new_a = {ar, ai};
    new_b = {br, bi};
    case (req_r)
      qsv_pkg::REQ_HAD: begin
        new_a = {hres[0], hres[1]};
        new_b = {hres[2], hres[3]};
      end
      qsv_pkg::REQ_X, qsv_pkg::REQ_CNOT: begin
        new_a = {br, bi};
        new_b = {ar, ai};
      end
      qsv_pkg::REQ_Y: begin
        new_a = {bi, qsv_pkg::neg_sat(br)};
        new_b = {qsv_pkg::neg_sat(ai), ar};
      end
      qsv_pkg::REQ_Z: begin
        new_b = {qsv_pkg::neg_sat(br), qsv_pkg::neg_sat(bi)};
      end
      default: begin
        new_a = {ar, ai};
        new_b = {br, bi};
      end
    endcase
  end

  always_comb begin
    unique case (k[1:0])
      2'd0: mul_op = qsv_pkg::SUM_W'(ar) + qsv_pkg::SUM_W'(br);
      2'd1: mul_op = qsv_pkg::SUM_W'(ai) + qsv_pkg::SUM_W'(bi);
      2'd2: mul_op = qsv_pkg::SUM_W'(ar) - qsv_pkg::SUM_W'(br);
      2'd3: mul_op = qsv_pkg::SUM_W'(ai) - qsv_pkg::SUM_W'(bi);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= qsv_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_waddr  = addr_i;
    ram_wdata  = new_a;
    ram_raddr  = addr_i;
    unique case (state)
      qsv_pkg::S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = (clr_addr == '0) ? {qsv_pkg::AMP_ONE, qsv_pkg::AMP_BITS'(0)} : '0;
        if (&clr_addr) begin
          state_next = clr_reply ? qsv_pkg::S_DONE : qsv_pkg::S_IDLE;
        end
      end
      qsv_pkg::S_IDLE: begin
        if (req_valid) begin
          priority if (req_type == qsv_pkg::REQ_INIT) begin
            state_next = qsv_pkg::S_CLEAR;
          end else if ((req_type == qsv_pkg::REQ_HAD || req_type == qsv_pkg::REQ_X ||
                        req_type == qsv_pkg::REQ_Y || req_type == qsv_pkg::REQ_Z) &&
                       gate_ok) begin
            state_next = qsv_pkg::S_RD_A;
          end else if (req_type == qsv_pkg::REQ_CNOT && cnot_ok) begin
            state_next = qsv_pkg::S_RD_A;
          end else if (req_type == qsv_pkg::REQ_READ && read_ok) begin
            state_next = qsv_pkg::S_AMP;
          end else begin
            state_next = qsv_pkg::S_DONE;
          end
        end
      end
      qsv_pkg::S_RD_A: begin
        if (cnot_skip) begin
          if (pair_last) begin
            state_next = qsv_pkg::S_DONE;
          end
        end else begin
          state_next = qsv_pkg::S_RD_B;
        end
      end
      qsv_pkg::S_RD_B: begin
        ram_raddr  = addr_j;
        state_next = qsv_pkg::S_LATCH;
      end
      qsv_pkg::S_LATCH: begin
        state_next = (req_r == qsv_pkg::REQ_HAD) ? qsv_pkg::S_MUL : qsv_pkg::S_WR_A;
      end
      qsv_pkg::S_MUL: begin
        if (k == 3'd4) begin
          state_next = qsv_pkg::S_WR_A;
        end
      end
      qsv_pkg::S_WR_A: begin
        ram_we     = 1'b1;
        state_next = qsv_pkg::S_WR_B;
      end
      qsv_pkg::S_WR_B: begin
        ram_we     = 1'b1;
        ram_waddr  = addr_j;
        ram_wdata  = new_b;
        state_next = pair_last ? qsv_pkg::S_DONE : qsv_pkg::S_RD_A;
      end
      qsv_pkg::S_AMP: begin
        ram_raddr  = idx_r;
        state_next = qsv_pkg::S_AMP_DATA;
      end
      qsv_pkg::S_AMP_DATA: begin
        state_next = qsv_pkg::S_DONE;
      end
      qsv_pkg::S_DONE: begin
        if (rsp_load) begin
          state_next = qsv_pkg::S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr  <= '0;
      clr_reply <= 1'b0;
      cnt       <= '0;
      k         <= '0;
    end else begin
      unique case (state)
        qsv_pkg::S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (&clr_addr) begin
            clr_reply <= 1'b0;
          end
        end
        qsv_pkg::S_IDLE: begin
          if (req_take) begin
            req_r    <= req_type;
            tq_r     <= target_qubit;
            cq_r     <= control_qubit;
            idx_r    <= amp_index;
            cnt      <= '0;
            res_real <= '0;
            res_imag <= '0;
            priority if (req_type == qsv_pkg::REQ_INIT) begin
              clr_reply  <= 1'b1;
              res_status <= qsv_pkg::STATUS_OK;
            end else if (req_type == qsv_pkg::REQ_HAD || req_type == qsv_pkg::REQ_X ||
                         req_type == qsv_pkg::REQ_Y || req_type == qsv_pkg::REQ_Z) begin
              res_status <= gate_ok ? qsv_pkg::STATUS_OK : qsv_pkg::STATUS_ERR;
            end else if (req_type == qsv_pkg::REQ_CNOT) begin
              res_status <= cnot_ok ? qsv_pkg::STATUS_OK : qsv_pkg::STATUS_ERR;
            end else if (req_type == qsv_pkg::REQ_READ) begin
              res_status <= read_ok ? qsv_pkg::STATUS_OK : qsv_pkg::STATUS_ERR;
            end else begin
              res_status <= qsv_pkg::STATUS_ERR;
            end
          end
        end
        qsv_pkg::S_RD_A: begin
          if (cnot_skip && !pair_last) begin
            cnt <= cnt + 1'b1;
          end
        end
        qsv_pkg::S_RD_B: begin
          {ar, ai} <= ram_rdata;
        end
        qsv_pkg::S_LATCH: begin
          {br, bi} <= ram_rdata;
          k        <= '0;
        end
        qsv_pkg::S_MUL: begin
          // product k enters the register while product k-1 is rounded
          if (k != 3'd4) begin
            prod <= qsv_pkg::PROD_W'(mul_op) * qsv_pkg::PROD_W'(qsv_pkg::HAD_COEF);
          end
          if (k != 3'd0) begin
            hres[2'(k - 3'd1)] <= qsv_pkg::had_round(prod);
          end
          k <= k + 1'b1;
        end
        qsv_pkg::S_WR_A: begin
        end
        qsv_pkg::S_WR_B: begin
          if (!pair_last) begin
            cnt <= cnt + 1'b1;
          end
        end
        qsv_pkg::S_AMP: begin
        end
        qsv_pkg::S_AMP_DATA: begin
          {res_real, res_imag} <= ram_rdata;
        end
        qsv_pkg::S_DONE: begin
        end
      endcase
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      amp_real <= res_real;
      amp_imag <= res_imag;
      status   <= res_status;
    end
  end

  qsv_ram #(
    .WIDTH (qsv_pkg::ENTRY_W),
    .DEPTH (qsv_pkg::STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

@@ src/qsv_checker.sv @@
module qsv_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                req_valid,
  input logic                                req_stall,
  input logic                                rsp_valid,
  input logic                                rsp_stall,
  input logic signed [qsv_pkg::AMP_BITS-1:0] amp_real,
  input logic signed [qsv_pkg::AMP_BITS-1:0] amp_imag,
  input logic                                status
);

  // a stalled response beat holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(amp_real) &&
                               $stable(amp_imag) && $stable(status))
    else $error("response beat changed while stalled");

  // the clearing pass follows reset
  a_reset_clear: assert property (@(posedge clk)
    rst |=> req_stall)
    else $error("request taken during clearing pass");

  // one request in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("second request taken back to back");

  // error responses carry zero amplitude
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status |-> amp_real == '0 && amp_imag == '0)
    else $error("error response with nonzero amplitude");

endmodule

bind qubit_state_vector_gate_engine qsv_checker u_qsv_checker (.*);

@@ dv/tb_qubit_state_vector_gate_engine.sv @@
module tb_qubit_state_vector_gate_engine;
  import qsv_pkg::*;

  typedef logic signed [AMP_BITS-1:0] amp_t;

  typedef struct packed {
    amp_t re;
    amp_t im;
    logic st;
  } rsp_t;

  typedef struct {
    logic        set_qc;
    logic [31:0] qc_val;
    logic [2:0]  kind;
    logic [3:0]  tq;
    logic [3:0]  cq;
    logic [9:0]  idx;
    logic        pinned;
    int          re;
    int          im;
    logic        st;
  } plan_row_t;

  localparam logic [REQ_W-1:0]   REQ_BAD    = 3'd7;
  localparam logic [PADDR_W-1:0] QC_ADDR    = PADDR_W'(4 * int'(REG_QUBIT_COUNT));
  localparam longint             HAD_MUL    = 46341;
  localparam longint             HALF_LSB   = 32768;
  localparam longint             AMP_TOP    = (longint'(1) <<< (AMP_BITS - 1)) - 1;
  localparam longint             AMP_BOT    = -AMP_TOP - 1;
  localparam int                 RAND_ITEMS = 540;
  localparam int                 LIMIT      = 10000000;
  localparam int                 PLAN_LEN   = 30;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  logic [REQ_W-1:0] req_type = REQ_INIT;
  logic [QIDX_W-1:0] target_qubit = '0;
  logic [QIDX_W-1:0] control_qubit = '0;
  logic [STORE_AW-1:0] amp_index = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  logic signed [AMP_BITS-1:0] amp_real;
  logic signed [AMP_BITS-1:0] amp_imag;
  logic status;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  // typed-in answer for the beat on the request port, if any
  logic pin_on = 1'b0;
  rsp_t pin_rsp = '0;
  logic calm = 1'b0;

  amp_t st_re [STORE_DEPTH];
  amp_t st_im [STORE_DEPTH];
  logic [3:0] qc_model;
  rsp_t awaited [$];
  int n_fail = 0;
  int n_req = 0;
  int n_rsp = 0;
  int n_rejected = 0;
  int n_cfg = 0;
  int hold_left = 0;
  int cycles = 0;

  qubit_state_vector_gate_engine dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall),
    .req_type(req_type), .target_qubit(target_qubit),
    .control_qubit(control_qubit), .amp_index(amp_index),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
    .amp_real(amp_real), .amp_imag(amp_imag), .status(status),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic report_miss(input string msg);
    n_fail++;
    $error("%s", msg);
  endtask

  function automatic int live_qubits();
    return (qc_model > MAX_QUBITS) ? MAX_QUBITS : int'(qc_model);
  endfunction

  function automatic void wipe_store();
    for (int i = 0; i < STORE_DEPTH; i++) begin
      st_re[i] = '0;
      st_im[i] = '0;
    end
    st_re[0] = amp_t'(longint'(1) <<< FRAC_BITS);
  endfunction

  // (a +/- b) / sqrt(2): round half away from zero, then clamp
  function automatic amp_t had_mix(input longint sum);
    longint prod;
    longint q;
    prod = sum * HAD_MUL;
    q = ((prod < 0 ? -prod : prod) + HALF_LSB) >>> 16;
    if (prod < 0) q = -q;
    if (q > AMP_TOP) q = AMP_TOP;
    else if (q < AMP_BOT) q = AMP_BOT;
    return amp_t'(q);
  endfunction

  function automatic amp_t flip(input amp_t x);
    return (longint'(x) == AMP_BOT) ? amp_t'(AMP_TOP) : amp_t'(-longint'(x));
  endfunction

  // Advance the amplitude store by one request and return its answer.
  function automatic rsp_t evolve_state(input logic [2:0] k, input logic [3:0] t,
                                        input logic [3:0] c, input logic [9:0] ix);
    rsp_t res;
    int n;
    int dim;
    int tb;
    int cb;
    int j;
    amp_t ar, ai, br, bi;
    res = '0;
    n = live_qubits();
    dim = 1 << n;
    case (k)
      REQ_INIT: wipe_store();
      REQ_HAD, REQ_X, REQ_Y, REQ_Z: begin
        if (t >= n) begin
          res.st = STATUS_ERR;
        end else begin
          tb = 1 << t;
          for (int i = 0; i < dim; i++) begin
            if ((i & tb) == 0) begin
              j = i | tb;
              ar = st_re[i]; ai = st_im[i];
              br = st_re[j]; bi = st_im[j];
              case (k)
                REQ_HAD: begin
                  st_re[i] = had_mix(longint'(ar) + longint'(br));
                  st_im[i] = had_mix(longint'(ai) + longint'(bi));
                  st_re[j] = had_mix(longint'(ar) - longint'(br));
                  st_im[j] = had_mix(longint'(ai) - longint'(bi));
                end
                REQ_X: begin
                  st_re[i] = br; st_im[i] = bi;
                  st_re[j] = ar; st_im[j] = ai;
                end
                REQ_Y: begin
                  st_re[i] = bi;       st_im[i] = flip(br);
                  st_re[j] = flip(ai); st_im[j] = ar;
                end
                default: begin
                  st_re[j] = flip(br); st_im[j] = flip(bi);
                end
              endcase
            end
          end
        end
      end
      REQ_CNOT: begin
        if (t >= n || c >= n || t == c) begin
          res.st = STATUS_ERR;
        end else begin
          tb = 1 << t;
          cb = 1 << c;
          for (int i = 0; i < dim; i++) begin
            if ((i & cb) != 0 && (i & tb) == 0) begin
              j = i | tb;
              ar = st_re[i]; ai = st_im[i];
              st_re[i] = st_re[j]; st_im[i] = st_im[j];
              st_re[j] = ar;       st_im[j] = ai;
            end
          end
        end
      end
      REQ_READ: begin
        if (ix >= dim) begin
          res.st = STATUS_ERR;
        end else begin
          res.re = st_re[ix];
          res.im = st_im[ix];
        end
      end
      default: res.st = STATUS_ERR;
    endcase
    return res;
  endfunction

  always @(posedge clk) begin : scoreboard
    rsp_t want;
    if (!rst) begin
      if (rsp_valid && !rsp_stall) begin
        n_rsp++;
        if (awaited.size() == 0) begin
          report_miss($sformatf("response beat with nothing pending: real %0d imag %0d status %0d",
                                amp_real, amp_imag, status));
        end else begin
          want = awaited.pop_front();
          if (amp_real !== want.re)
            report_miss($sformatf("amp_real: expected %0d, got %0d", want.re, amp_real));
          if (amp_imag !== want.im)
            report_miss($sformatf("amp_imag: expected %0d, got %0d", want.im, amp_imag));
          if (status !== want.st)
            report_miss($sformatf("status: expected %0d, got %0d", want.st, status));
        end
      end
      if (req_valid && !req_stall) begin
        want = evolve_state(req_type, target_qubit, control_qubit, amp_index);
        if (pin_on) want = pin_rsp;
        if (want.st == STATUS_ERR) n_rejected++;
        awaited.push_back(want);
        n_req++;
      end
    end
  end

  // receiver: mostly ready, short stalls, a few long ones
  always @(posedge clk) begin : rsp_pacer
    int r;
    if (rst || calm) begin
      rsp_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else begin
      r = $urandom_range(0, 99);
      rsp_stall <= (r >= 55);
      hold_left <= (r < 55) ? $urandom_range(0, 6) :
                   (r < 92) ? $urandom_range(0, 3) : $urandom_range(10, 60);
    end
  end

  // Drop valid and hold until every answer has come back.
  task automatic drain();
    req_valid <= 1'b0;
    @(posedge clk);
    while (awaited.size() != 0) @(posedge clk);
  endtask

  task automatic write_qubit_count(input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= QC_ADDR;
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    qc_model = val[3:0];
    n_cfg++;
    // read back
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {28'd0, qc_model})
      report_miss($sformatf("qubit_count: expected %0d, got %0d", qc_model, prdata));
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic send_req(input logic [2:0] k, input logic [3:0] t, input logic [3:0] c,
                          input logic [9:0] ix, input logic pinned, input rsp_t pv);
    int r;
    int gap;
    r = $urandom_range(0, 99);
    gap = calm ? 0 : (r < 65) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(8, 40);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req_type <= k;
    target_qubit <= t;
    control_qubit <= c;
    amp_index <= ix;
    pin_on <= pinned;
    pin_rsp <= pv;
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  plan_row_t plan [PLAN_LEN] = '{
    '{1'b0, 32'd0,  REQ_READ, 4'd0,  4'd0,  10'd0,    1'b1, 65536, 0, STATUS_OK},
    '{1'b0, 32'd0,  REQ_READ, 4'd0,  4'd0,  10'd1,    1'b1, 0,     0, STATUS_OK},
    '{1'b0, 32'd0,  REQ_READ, 4'd0,  4'd0,  10'd2,    1'b1, 0,     0, STATUS_ERR},
    '{1'b0, 32'd0,  REQ_BAD,  4'd15, 4'd15, 10'd1023, 1'b1, 0,     0, STATUS_ERR},
    '{1'b0, 32'd0,  REQ_HAD,  4'd0,  4'd9,  10'd0,    1'b1, 0,     0, STATUS_OK},
    '{1'b0, 32'd0,  REQ_READ, 4'd0,  4'd0,  10'd0,    1'b1, 46341, 0, STATUS_OK},
    '{1'b0, 32'd0,  REQ_READ, 4'd0,  4'd0,  10'd1,    1'b1, 46341, 0, STATUS_OK},
    '{1'b0, 32'd0,  REQ_HAD,  4'd1,  4'd0,  10'd0,    1'b1, 0,     0, STATUS_ERR},
    '{1'b1, 32'd3,  REQ_INIT, 4'd0,  4'd0,  10'd0,    1'b0, 0,     0, STATUS_OK},
    '{1'b0, 32'd0,  REQ_CNOT, 4'd1,  4'd1,  10'd0,    1'b1, 0,     0, STATUS_ERR},
    '{1'b0, 32'd0,  REQ_CNOT, 4'd2,  4'd0,  10'd0,    1'b0, 0,     0, STATUS_OK},
    '{1'b0, 32'd0,  REQ_Y,    4'd1,  4'd0,  10'd0,    1'b0, 0,     0, STATUS_OK},
    '{1'b0, 32'd0,  REQ_Z,    4'd2,  4'd0,  10'd0,    1'b0, 0,     0, STATUS_OK},
    '{1'b0, 32'd0,  REQ_READ, 4'd0,  4'd0,  10'd5,    1'b0, 0,     0, STATUS_OK},
    '{1'b0, 32'd0,  REQ_READ, 4'd0,  4'd0,  10'd8,    1'b1, 0,     0, STATUS_ERR},
    '{1'b1, 32'd0,  REQ_INIT, 4'd0,  4'd0,  10'd0,    1'b0, 0,     0, STATUS_OK},
    '{1'b0, 32'd0,  REQ_HAD,  4'd0,  4'd0,  10'd0,    1'b1, 0,     0, STATUS_ERR},
    '{1'b0, 32'd0,  REQ_READ, 4'd0,  4'd0,  10'd0,    1'b0, 0,     0, STATUS_OK},
    '{1'b0, 32'd0,  REQ_READ, 4'd0,  4'd0,  10'd1,    1'b1, 0,     0, STATUS_ERR},
    '{1'b1, 32'd10, REQ_INIT, 4'd0,  4'd0,  10'd0,    1'b0, 0,     0, STATUS_OK},
    '{1'b0, 32'd0,  REQ_X,    4'd9,  4'd0,  10'd0,    1'b0, 0,     0, STATUS_OK},
    '{1'b0, 32'd0,  REQ_CNOT, 4'd9,  4'd15, 10'd0,    1'b1, 0,     0, STATUS_ERR},
    '{1'b0, 32'd0,  REQ_HAD,  4'd9,  4'd0,  10'd0,    1'b0, 0,     0, STATUS_OK},
    '{1'b0, 32'd0,  REQ_CNOT, 4'd0,  4'd9,  10'd0,    1'b0, 0,     0, STATUS_OK},
    '{1'b0, 32'd0,  REQ_READ, 4'd0,  4'd0,  10'd513,  1'b0, 0,     0, STATUS_OK},
    '{1'b1, 32'd15, REQ_INIT, 4'd0,  4'd0,  10'd0,    1'b0, 0,     0, STATUS_OK},
    '{1'b0, 32'd0,  REQ_Y,    4'd15, 4'd0,  10'd0,    1'b1, 0,     0, STATUS_ERR},
    '{1'b0, 32'd0,  REQ_Z,    4'd9,  4'd0,  10'd0,    1'b0, 0,     0, STATUS_OK},
    '{1'b0, 32'd0,  REQ_INIT, 4'd0,  4'd0,  10'd0,    1'b1, 0,     0, STATUS_OK},
    '{1'b0, 32'd0,  REQ_READ, 4'd0,  4'd0,  10'd0,    1'b1, 65536, 0, STATUS_OK}
  };

  initial begin : stimulus
    rsp_t pv;
    logic [2:0] k;
    logic [3:0] t;
    logic [3:0] c;
    logic [9:0] ix;
    logic [3:0] qc;
    int n;
    int r;
    int n_rand;
    int ph;
    int burst;
    wipe_store();
    qc_model = 4'd1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // hold off while the store is being cleared
    while (req_stall) @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].set_qc) begin
        drain();
        write_qubit_count(plan[i].qc_val);
      end else begin
        pv.re = amp_t'(plan[i].re);
        pv.im = amp_t'(plan[i].im);
        pv.st = plan[i].st;
        send_req(plan[i].kind, plan[i].tq, plan[i].cq, plan[i].idx, plan[i].pinned, pv);
      end
    end

    n_rand = 0;
    ph = 0;
    while (n_rand < RAND_ITEMS) begin
      if (ph == 2 || ph == 9) qc = 4'd10;
      else if (ph == 5) qc = 4'd0;
      else if (ph == 7) qc = 4'($urandom_range(11, 15));
      else if (ph % 4 == 3) qc = 4'($urandom_range(5, 9));
      else qc = 4'($urandom_range(1, 4));
      drain();
      write_qubit_count(($urandom() & 32'hFFFF_FFF0) | {28'd0, qc});
      calm <= ($urandom_range(0, 4) == 0);
      n = live_qubits();
      burst = (n >= 5) ? 12 : (n == 0) ? 20 : 45;
      for (int b = 0; b < burst; b++) begin
        k = 3'($urandom());
        t = 4'($urandom());
        c = 4'($urandom());
        ix = 10'($urandom());
        r = $urandom_range(0, 99);
        if (r < 3) k = REQ_INIT;
        else if (r < 20) k = REQ_HAD;
        else if (r < 32) k = REQ_X;
        else if (r < 44) k = REQ_Y;
        else if (r < 54) k = REQ_Z;
        else if (r < 70) k = REQ_CNOT;
        else if (r < 93) k = REQ_READ;
        else k = 3'($urandom_range(1, 7)); // noise: wild qubits, wild index, bad code
        if (r < 93 && n > 0) begin
          t = 4'($urandom_range(0, n - 1));
          if (k == REQ_CNOT && n > 1) begin
            c = 4'($urandom_range(0, n - 2));
            if (c >= t) c = c + 4'd1;
          end
          ix = 10'($urandom_range(0, (1 << n) - 1));
        end
        send_req(k, t, c, ix, 1'b0, '0);
        n_rand++;
        if ($urandom_range(0, 59) == 0) drain();
      end
      ph++;
    end

    drain();
    calm <= 1'b1;
    repeat (20) @(posedge clk);
    $display("Covered %0d requests (%0d rejected) over %0d qubit-count writes,", n_req,
             n_rejected, n_cfg);
    $display("from no qubits up to the full store, with %0d response beats checked.", n_rsp);
    if (n_fail == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
